### hdl/ssbmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssbmd_pkg;

  // Default largest block size (samples per result)
  localparam int MAX_BLOCK_DEF = 65536;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int PMEAN_W  = 15;
  localparam int NMEAN_W  = 16;
  localparam int BS_W     = 17;

  // Stream data widths, padded to whole bytes
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_BIT = 2;
  localparam logic REG_BLOCK_SIZE = 1'b0;

  // Quotient bits per division; both means fit in 16 bits
  localparam int QW     = 16;
  localparam int STEP_W = $clog2(QW);

  // Queue between accumulator and divider
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_t;

endpackage

`default_nettype wire

### hdl/ssbmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ssbmd_fifo #(
  parameter int W = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push_valid,
  output logic                                   push_ready,
  input  wire logic [W-1:0]                      push_data,
  output logic                                   pop_valid,
  input  wire logic                              pop_ready,
  output logic [W-1:0]                           pop_data,
  output logic [ssbmd_pkg::FIFO_LVL_W-1:0]       level
);
  import ssbmd_pkg::*;

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  logic [W-1:0]          mem [FIFO_DEPTH];
  logic [PW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_LVL_W-1:0] cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign push_ready = (cnt_r != FIFO_LVL_W'(FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign level      = cnt_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + FIFO_LVL_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - FIFO_LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### hdl/ssbmd_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Sort samples by sign, accumulate, and push block totals at block end.
// Totals are packed {ncnt, nsum, pcnt, psum}, psum in the low bits.
module ssbmd_front #(
  parameter int MAX_BLOCK = ssbmd_pkg::MAX_BLOCK_DEF,
  parameter int CW        = $clog2(MAX_BLOCK + 1),
  parameter int QDW       = 4 * CW + ssbmd_pkg::PMEAN_W + ssbmd_pkg::SAMPLE_W
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [CW-1:0]                       eff_size,
  input  wire logic                                s_valid,
  output logic                                     s_ready,
  input  wire logic signed [ssbmd_pkg::SAMPLE_W-1:0] s_sample,
  output logic                                     push_valid,
  input  wire logic                                push_ready,
  output logic [QDW-1:0]                           push_data
);
  import ssbmd_pkg::*;

  localparam int PSW = CW + PMEAN_W;
  localparam int NSW = CW + SAMPLE_W;

  logic [PSW-1:0]    psum_r, psum_add;
  logic [NSW-1:0]    nsum_r, nsum_add;
  logic [CW-1:0]     pcnt_r, pcnt_add;
  logic [CW-1:0]     ncnt_r, ncnt_add;
  logic [CW-1:0]     tot_r, tot_add;
  logic [SAMPLE_W:0] mag;
  logic              is_neg, accept, end_blk;

  assign s_ready = push_ready;
  assign accept  = s_valid && push_ready;
  assign is_neg  = s_sample[SAMPLE_W-1];
  // magnitude of a negative sample, up to 2^15
  assign mag     = (SAMPLE_W + 1)'(0) - {s_sample[SAMPLE_W-1], s_sample};
  assign end_blk = (tot_r >= eff_size - CW'(1));

  always_comb begin
    psum_add = psum_r;
    nsum_add = nsum_r;
    pcnt_add = pcnt_r;
    ncnt_add = ncnt_r;
    tot_add  = tot_r + CW'(1);
    if (is_neg) begin
      nsum_add = nsum_r + NSW'(mag);
      ncnt_add = ncnt_r + CW'(1);
    end else begin
      psum_add = psum_r + PSW'(s_sample[PMEAN_W-1:0]);
      pcnt_add = pcnt_r + CW'(1);
    end
  end

  assign push_valid = accept && end_blk;
  assign push_data  = {ncnt_add, nsum_add, pcnt_add, psum_add};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psum_r <= '0;
      nsum_r <= '0;
      pcnt_r <= '0;
      ncnt_r <= '0;
      tot_r  <= '0;
    end else if (accept) begin
      if (end_blk) begin
        psum_r <= '0;
        nsum_r <= '0;
        pcnt_r <= '0;
        ncnt_r <= '0;
        tot_r  <= '0;
      end else begin
        psum_r <= psum_add;
        nsum_r <= nsum_add;
        pcnt_r <= pcnt_add;
        ncnt_r <= ncnt_add;
        tot_r  <= tot_add;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/ssbmd_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Two restoring dividers, one quotient bit per cycle each, then an
// output register.
module ssbmd_back #(
  parameter int MAX_BLOCK = ssbmd_pkg::MAX_BLOCK_DEF,
  parameter int CW        = $clog2(MAX_BLOCK + 1),
  parameter int QDW       = 4 * CW + ssbmd_pkg::PMEAN_W + ssbmd_pkg::SAMPLE_W
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 pop_valid,
  output logic                                      pop_ready,
  input  wire logic [QDW-1:0]                       pop_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [ssbmd_pkg::OUT_TDATA_W-1:0]         out_data
);
  import ssbmd_pkg::*;

  localparam int PSW = CW + PMEAN_W;
  localparam int NSW = CW + SAMPLE_W;
  localparam int DW  = CW + QW;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QW - 1);

  back_state_t state_r, state_nxt;

  logic [PSW-1:0]    in_psum;
  logic [NSW-1:0]    in_nsum;
  logic [CW-1:0]     in_pcnt, in_ncnt;
  logic [DW-1:0]     pext, next;

  logic [CW-1:0]     prem_r, nrem_r, pdiv_r, ndiv_r;
  logic [QW-1:0]     plo_r, nlo_r;
  logic              pzero_r, nzero_r;
  logic [STEP_W-1:0] step_r;

  logic [CW:0]       prem_sh, nrem_sh, pdiff, ndiff;
  logic              pge, nge;

  logic              load, run, fin_wr;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [PMEAN_W-1:0]     pmean;
  logic [NMEAN_W-1:0]     nmean;

  assign {in_ncnt, in_nsum, in_pcnt, in_psum} = pop_data;
  assign pext = DW'(in_psum);
  assign next = DW'(in_nsum);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (pop_valid) state_nxt = BK_DIV;
      BK_DIV:  if (step_r == STEP_LAST) state_nxt = BK_FIN;
      BK_FIN:  if (!out_valid_r || out_ready) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop_ready = 1'b0;
    load      = 1'b0;
    run       = 1'b0;
    fin_wr    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        pop_ready = 1'b1;
        load      = pop_valid;
      end
      BK_DIV: begin
        run = 1'b1;
      end
      BK_FIN: begin
        fin_wr = !out_valid_r || out_ready;
      end
      default: begin
        pop_ready = 1'b0;
      end
    endcase
  end

  // One restoring step per divider
  assign prem_sh = {prem_r, plo_r[QW-1]};
  assign nrem_sh = {nrem_r, nlo_r[QW-1]};
  assign pdiff   = prem_sh - {1'b0, pdiv_r};
  assign ndiff   = nrem_sh - {1'b0, ndiv_r};
  assign pge     = !pdiff[CW];
  assign nge     = !ndiff[CW];

  assign pmean = pzero_r ? '0 : plo_r[PMEAN_W-1:0];
  assign nmean = nzero_r ? '0 : NMEAN_W'(0) - nlo_r[NMEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (fin_wr) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        step_r <= '0;
      end else if (run) begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prem_r  <= pext[DW-1:QW];
      plo_r   <= pext[QW-1:0];
      nrem_r  <= next[DW-1:QW];
      nlo_r   <= next[QW-1:0];
      pdiv_r  <= in_pcnt;
      ndiv_r  <= in_ncnt;
      pzero_r <= (in_pcnt == '0);
      nzero_r <= (in_ncnt == '0);
    end else if (run) begin
      prem_r <= pge ? pdiff[CW-1:0] : prem_sh[CW-1:0];
      plo_r  <= {plo_r[QW-2:0], pge};
      nrem_r <= nge ? ndiff[CW-1:0] : nrem_sh[CW-1:0];
      nlo_r  <= {nlo_r[QW-2:0], nge};
    end
    if (fin_wr) begin
      out_data_r <= OUT_TDATA_W'({nmean, pmean});
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### hdl/sign_split_block_mean_decimator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Sign-split block mean decimator.
// Throughput: one sample per cycle into the accumulator while the queue has room;
//   the divider back end takes one block at a time (load, 16 quotient bits, result write).
// Path from the transaction that ends a block to out_tvalid: queue, load, division, output register.
// Reset (synchronous, rst_n low): clears sums, counts, queue and output valid;
//   block_size returns to 1.
module sign_split_block_mean_decimator_unit #(
  parameter int MAX_BLOCK = ssbmd_pkg::MAX_BLOCK_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // sample_value[15:0]
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [ssbmd_pkg::IN_TDATA_W-1:0]  in_tdata,
  // positive_mean[14:0], negative_mean[30:15], zero [31]
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [ssbmd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // configuration port
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [ssbmd_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [ssbmd_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [ssbmd_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                   cfg_pready
);
  import ssbmd_pkg::*;

  localparam int CW  = $clog2(MAX_BLOCK + 1);
  localparam int QDW = 4 * CW + PMEAN_W + SAMPLE_W;
  localparam int EW  = (BS_W > CW) ? BS_W : CW;

  logic [BS_W-1:0]       block_size_r;
  logic [EW-1:0]         bs_ext, eff_ext;
  logic [CW-1:0]         eff_size;
  logic                  cfg_wr;

  logic                  push_valid, push_ready;
  logic [QDW-1:0]        push_data;
  logic                  pop_valid, pop_ready;
  logic [QDW-1:0]        pop_data;
  logic [FIFO_LVL_W-1:0] q_level;

  // Register access: write on the access phase, reads are zero-wait
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[CFG_IDX_BIT] == REG_BLOCK_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BS_W'(1);
    end else if (cfg_wr) begin
      block_size_r <= cfg_pwdata[BS_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_IDX_BIT] == REG_BLOCK_SIZE)
                      ? CFG_DATA_W'(block_size_r) : '0;

  // Effective block size: zero acts as one, large values clamp to MAX_BLOCK
  assign bs_ext = EW'(block_size_r);
  always_comb begin
    if (bs_ext == '0) begin
      eff_ext = EW'(1);
    end else if (bs_ext > EW'(MAX_BLOCK)) begin
      eff_ext = EW'(MAX_BLOCK);
    end else begin
      eff_ext = bs_ext;
    end
  end
  assign eff_size = eff_ext[CW-1:0];

  // Front end: sort and accumulate, hand block totals to the queue
  ssbmd_front #(
    .MAX_BLOCK (MAX_BLOCK),
    .CW        (CW),
    .QDW       (QDW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_size   (eff_size),
    .s_valid    (in_tvalid),
    .s_ready    (in_tready),
    .s_sample   (in_tdata[SAMPLE_W-1:0]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Short queue: lets the accumulator keep taking samples while dividing
  ssbmd_fifo #(
    .W (QDW)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .level      (q_level)
  );

  // Back end: divide both sums by their counts, hold the result
  ssbmd_back #(
    .MAX_BLOCK (MAX_BLOCK),
    .CW        (CW),
    .QDW       (QDW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

  // Queue never holds more than its depth
  a_q_level: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= FIFO_LVL_W'(FIFO_DEPTH))
    else $error("queue level above depth");

  // Input stalls only when the queue is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (q_level == FIFO_LVL_W'(FIFO_DEPTH)))
    else $error("input stalled with room in queue");

  // Negative mean is zero or negative
  a_neg_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[30] || (out_tdata[30:15] == '0)))
    else $error("negative mean has wrong sign");

  // No result right after reset
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

`default_nettype wire
